// ----- src/bfba_pkg.sv -----
package bfba_pkg;

  localparam int MaxBlocks   = 32768;
  localparam int WordBits    = 32;
  localparam int MapWords    = MaxBlocks / WordBits;
  localparam int BlkW        = $clog2(MaxBlocks);
  localparam int CntW        = BlkW + 1;
  localparam int WordIdxW    = $clog2(MapWords);
  localparam int BitIdxW     = $clog2(WordBits);
  localparam int TotalW      = 16;
  localparam int BsizeW      = 17;
  localparam int CfgIdxW     = 1;

  typedef enum logic [1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSPC = 2'd1,
    ST_ARG   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOTAL = 1'd0,
    REG_BSIZE = 1'd1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT_DIV,
    S_FMT,
    S_SCAN_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK,
    S_CLR_RD,
    S_CLR,
    S_QRY_RD,
    S_QRY,
    S_CLEAR,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch command and arguments
    logic div_start;
    logic rd;         // read word at cursor
    logic scan_step;  // examine read word for a free run
    logic set_step;   // write back word with run bits set
    logic clr_step;   // write back word with run bits cleared
    logic fmt_step;   // write formatted word
    logic wipe_step;  // write zero word (reset sweep)
    logic res_load;   // latch result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic arg_err;
    logic div_done;
    logic found;
    logic last_word;  // cursor at final word of current walk
    logic walk_done;  // run fully written
  } dp_sts_t;

endpackage

// ----- src/bfba_div.sv -----
// Radix-2 restoring divider, one quotient bit a cycle
module bfba_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bfba_pkg::TotalW-1:0]   num_i,
  input  logic [bfba_pkg::BsizeW-1:0]   den_i,
  output logic                          done_o,
  output logic [bfba_pkg::TotalW-1:0]   quo_o
);
  localparam int NW = bfba_pkg::TotalW;
  localparam int RW = bfba_pkg::BsizeW + 1;

  logic [NW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d, trial;
  logic [$clog2(NW+1)-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [bfba_pkg::BsizeW-1:0] den_q, den_d;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    den_d  = den_q;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = ($clog2(NW+1))'(NW);
      busy_d = 1'b1;
      den_d  = den_i;
    end else if (busy_q) begin
      trial = {rem_q[RW-2:0], quo_q[NW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ($clog2(NW+1))'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == ($clog2(NW+1))'(1));
  assign quo_o  = quo_d;
endmodule

// ----- src/bfba_ctrl.sv -----
module bfba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [1:0]        cmd_i,
  input  bfba_pkg::dp_sts_t sts_i,
  output bfba_pkg::dp_cmd_t cmd_o
);
  bfba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      bfba_pkg::S_CLEAR: begin
        cmd_o.wipe_step = 1'b1;
        if (sts_i.last_word) state_d = bfba_pkg::S_IDLE;
      end
      bfba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (bfba_pkg::cmd_e'(cmd_i))
            bfba_pkg::CMD_FORMAT: begin
              cmd_o.div_start = 1'b1;
              state_d = bfba_pkg::S_FMT_DIV;
            end
            bfba_pkg::CMD_ALLOC: state_d = bfba_pkg::S_SCAN_RD;
            bfba_pkg::CMD_FREE:  state_d = bfba_pkg::S_CLR_RD;
            default:             state_d = bfba_pkg::S_QRY_RD;
          endcase
        end
      end
      bfba_pkg::S_FMT_DIV: if (sts_i.div_done) state_d = bfba_pkg::S_FMT;
      bfba_pkg::S_FMT: begin
        cmd_o.fmt_step = 1'b1;
        if (sts_i.last_word) begin
          cmd_o.res_load = 1'b1;
          state_d = bfba_pkg::S_OUT;
        end
      end
      bfba_pkg::S_SCAN_RD: begin
        if (sts_i.arg_err) begin
          cmd_o.res_load = 1'b1;
          state_d = bfba_pkg::S_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = bfba_pkg::S_SCAN;
        end
      end
      bfba_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.found) state_d = bfba_pkg::S_MARK_RD;
        else if (sts_i.last_word) begin
          cmd_o.res_load = 1'b1;
          state_d = bfba_pkg::S_OUT;
        end else begin
          // fetch the next word once the cursor has advanced
          state_d = bfba_pkg::S_SCAN_RD;
        end
      end
      bfba_pkg::S_MARK_RD: begin
        cmd_o.rd = 1'b1;
        state_d = bfba_pkg::S_MARK;
      end
      bfba_pkg::S_MARK: begin
        cmd_o.set_step = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.res_load = 1'b1;
          state_d = bfba_pkg::S_OUT;
        end else state_d = bfba_pkg::S_MARK_RD;
      end
      bfba_pkg::S_CLR_RD: begin
        if (sts_i.arg_err) begin
          cmd_o.res_load = 1'b1;
          state_d = bfba_pkg::S_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = bfba_pkg::S_CLR;
        end
      end
      bfba_pkg::S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.res_load = 1'b1;
          state_d = bfba_pkg::S_OUT;
        end else state_d = bfba_pkg::S_CLR_RD;
      end
      bfba_pkg::S_QRY_RD: begin
        cmd_o.rd = 1'b1;
        state_d = bfba_pkg::S_QRY;
      end
      bfba_pkg::S_QRY: begin
        cmd_o.res_load = 1'b1;
        state_d = bfba_pkg::S_OUT;
      end
      bfba_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = bfba_pkg::S_IDLE;
      end
      default: state_d = bfba_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- src/bfba_dp.sv -----
module bfba_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bfba_pkg::BsizeW-1:0] cfg_data_i,
  input  logic [1:0]                  cmd_i,
  input  logic [15:0]                 count_i,
  input  logic [14:0]                 first_i,
  input  bfba_pkg::dp_cmd_t           cmd_s_i,
  output bfba_pkg::dp_sts_t           sts_o,
  output logic [1:0]                  status_o,
  output logic [14:0]                 run_start_o,
  output logic                        block_used_o
);
  localparam int WB  = bfba_pkg::WordBits;
  localparam int WIW = bfba_pkg::WordIdxW;
  localparam int BIW = bfba_pkg::BitIdxW;
  localparam int CW  = bfba_pkg::CntW;
  localparam int BW  = bfba_pkg::BlkW;

  logic [bfba_pkg::TotalW-1:0] total_q;
  logic [bfba_pkg::BsizeW-1:0] bsize_q;
  logic [WB-1:0] mem [bfba_pkg::MapWords];
  logic [WB-1:0] rdata_q;

  logic [1:0]    op_q;
  logic [CW-1:0] count_q, t_eff;
  logic [BW-1:0] first_q;
  logic [WIW-1:0] wptr_q;
  logic [CW-1:0] run_q;             // run length
  logic [CW-1:0] lo_q, hi_q;        // range being walked [lo, hi)
  logic [BW-1:0] found_s_q;
  logic          found_q;
  logic [1:0]    status_q, status_d;
  logic [BW-1:0] rstart_q, rstart_d;
  logic          bused_q, bused_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bfba_pkg::TotalW'(32768);
      bsize_q <= bfba_pkg::BsizeW'(512);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bfba_pkg::REG_TOTAL) total_q <= cfg_data_i[bfba_pkg::TotalW-1:0];
      else bsize_q <= cfg_data_i;
    end
  end

  assign t_eff = (32'(total_q) > bfba_pkg::MaxBlocks) ? CW'(bfba_pkg::MaxBlocks)
                                                     : CW'(total_q);

  // reserved count: ((t/8+1)/bs + 1) + 1 clamped to t
  logic [bfba_pkg::TotalW-1:0] quo;
  logic div_done;
  bfba_div u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_s_i.div_start),
    .num_i   (bfba_pkg::TotalW'((t_eff >> 3) + 1'b1)),
    .den_i   ((bsize_q == '0) ? bfba_pkg::BsizeW'(1) : bsize_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );
  logic [bfba_pkg::TotalW+1:0] rsv_raw;
  assign rsv_raw = {2'b00, quo} + 2'd2;

  // word masks for [lo,hi) intersected with word wptr
  logic [CW-1:0] wbase;
  logic [WB-1:0] rng_mask;
  always_comb begin
    wbase = CW'(wptr_q) << BIW;
    for (int k = 0; k < WB; k++)
      rng_mask[k] = ((wbase + CW'(k)) >= lo_q) && ((wbase + CW'(k)) < hi_q);
  end

  logic [WB-1:0] wr_data;
  logic          wr_en;
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rdata_q;
    if (cmd_s_i.wipe_step) begin
      wr_en = 1'b1; wr_data = '0;
    end else if (cmd_s_i.fmt_step) begin
      wr_en = 1'b1; wr_data = rng_mask;
    end else if (cmd_s_i.set_step) begin
      wr_en = 1'b1; wr_data = rdata_q | rng_mask;
    end else if (cmd_s_i.clr_step) begin
      wr_en = 1'b1; wr_data = rdata_q & ~rng_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wptr_q] <= wr_data;
    if (cmd_s_i.rd) rdata_q <= mem[wptr_q];
  end

  // scan one word: blocks at or above t count as used; the run ending at
  // each bit is either the carried run plus the bits so far, or the
  // distance to the nearest used bit below it
  logic [WB-1:0] occ;
  logic [CW-1:0] run_at [WB];
  logic [CW-1:0] run_n;
  logic          hit;
  logic [CW-1:0] hit_end;
  always_comb begin
    for (int k = 0; k < WB; k++)
      occ[k] = rdata_q[k] || ((wbase + CW'(k)) >= t_eff);
    for (int k = 0; k < WB; k++) begin
      run_at[k] = run_q + CW'(k + 1);
      for (int j = 0; j <= k; j++)
        if (occ[j]) run_at[k] = CW'(k - j);
    end
    hit     = 1'b0;
    hit_end = '0;
    for (int k = 0; k < WB; k++) begin
      if (!hit && !occ[k] && (run_at[k] == count_q)) begin
        hit = 1'b1;
        hit_end = wbase + CW'(k);
      end
    end
    run_n = run_at[WB-1];
  end

  logic last_scan, walk_last;
  assign last_scan = (wptr_q == {WIW{1'b1}}) || ((wbase + CW'(WB)) >= t_eff);
  assign walk_last = ((wbase + CW'(WB)) >= hi_q);

  logic arg_err;
  always_comb begin
    case (bfba_pkg::cmd_e'(op_q))
      bfba_pkg::CMD_ALLOC: arg_err = (count_q == '0) || (count_q > t_eff);
      bfba_pkg::CMD_FREE:  arg_err = (count_q == '0) ||
                                     (({1'b0, CW'(first_q)} + {1'b0, count_q}) >
                                      {1'b0, t_eff});
      bfba_pkg::CMD_QUERY: arg_err = CW'(first_q) >= t_eff;
      default:             arg_err = 1'b0;
    endcase
  end

  always_comb begin
    status_d = bfba_pkg::ST_OK;
    rstart_d = '0;
    bused_d  = 1'b0;
    if (arg_err) status_d = bfba_pkg::ST_ARG;
    else case (bfba_pkg::cmd_e'(op_q))
      bfba_pkg::CMD_FORMAT: rstart_d = BW'(1);
      bfba_pkg::CMD_ALLOC: begin
        if (found_q) rstart_d = found_s_q;
        else status_d = bfba_pkg::ST_NOSPC;
      end
      bfba_pkg::CMD_QUERY: bused_d = rdata_q[first_q[BIW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
    end else if (cmd_s_i.wipe_step) begin
      wptr_q <= wptr_q + 1'b1;
    end else if (cmd_s_i.load) begin
      wptr_q <= (bfba_pkg::cmd_e'(cmd_i) == bfba_pkg::CMD_FREE ||
                 bfba_pkg::cmd_e'(cmd_i) == bfba_pkg::CMD_QUERY)
                ? WIW'(first_i >> BIW) : '0;
    end else if (cmd_s_i.scan_step) begin
      if (hit) wptr_q <= WIW'((hit_end + 1'b1 - count_q) >> BIW);
      else wptr_q <= wptr_q + 1'b1;
    end else if (cmd_s_i.fmt_step || cmd_s_i.set_step || cmd_s_i.clr_step) begin
      wptr_q <= wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_s_i.load) begin
      op_q    <= cmd_i;
      count_q <= CW'(count_i);
      first_q <= BW'(first_i);
      run_q   <= '0;
      found_q <= 1'b0;
      lo_q    <= CW'(first_i);
      hi_q    <= CW'(first_i) + CW'(count_i);
    end
    if (div_done) begin
      lo_q <= '0;
      hi_q <= (rsv_raw > ($bits(rsv_raw))'(t_eff)) ? t_eff : CW'(rsv_raw);
    end
    if (cmd_s_i.scan_step) begin
      run_q <= run_n;
      if (hit) begin
        found_q   <= 1'b1;
        found_s_q <= BW'(hit_end + 1'b1 - count_q);
        lo_q      <= hit_end + 1'b1 - count_q;
        hi_q      <= hit_end + 1'b1;
      end
    end
    if (cmd_s_i.res_load) begin
      status_q <= status_d;
      rstart_q <= rstart_d;
      bused_q  <= bused_d;
    end
  end

  assign sts_o.arg_err   = arg_err;
  assign sts_o.div_done  = div_done;
  assign sts_o.found     = hit;
  assign sts_o.last_word = cmd_s_i.wipe_step ? (wptr_q == {WIW{1'b1}})
                         : cmd_s_i.fmt_step ? (wptr_q == {WIW{1'b1}}) : last_scan;
  assign sts_o.walk_done = walk_last;

  assign status_o     = status_q;
  assign run_start_o  = 15'(rstart_q);
  assign block_used_o = bused_q;
endmodule

// ----- src/bitmap_first_fit_block_allocator.sv -----
// First-fit bitmap block allocator. Takes one command beat at a time and
// returns one result beat. After reset the map is wiped one 32-bit word a
// cycle, all 1024 words, before the first command is taken. Format runs the
// divider to size the reserved area, then rewrites every map word; allocate
// reads and scans map words in order up to the first fit, then reads and
// rewrites each word of the run to mark it; free reads and rewrites each word
// of the run; query reads one word. The map is accessed one word at a time
// on a single-port array.
module bitmap_first_fit_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd[1:0], block_count[17:2], first_block[32:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[1:0], run_start[16:2], block_used[17]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_data_i
);
  bfba_pkg::dp_cmd_t dcmd;
  bfba_pkg::dp_sts_t dsts;
  logic [1:0]  status;
  logic [14:0] run_start;
  logic        block_used;

  bfba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (s_axis_tdata[1:0]),
    .sts_i       (dsts),
    .cmd_o       (dcmd)
  );

  bfba_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i        (s_axis_tdata[1:0]),
    .count_i      (s_axis_tdata[17:2]),
    .first_i      (s_axis_tdata[32:18]),
    .cmd_s_i      (dcmd),
    .sts_o        (dsts),
    .status_o     (status),
    .run_start_o  (run_start),
    .block_used_o (block_used)
  );

  assign m_axis_tdata = {6'd0, block_used, run_start, status};
endmodule
